@@ hdl/osdt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// osdt_pkg
// Shared types and constants of the one-shot delay timer table: request and
// result layouts, command and result codes, and the control and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package osdt_pkg;

    localparam int TICK_W      = 32;
    localparam int ID_W        = 8;
    localparam int SLOT_W      = 3;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_ADD0 = 2'd2,
        CMD_SCAN = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_ADDED = 2'd1,
        KIND_FULL  = 2'd2,
        KIND_FIRED = 2'd3
    } kind_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [TICK_W-1:0] delay_ticks;
        logic [ID_W-1:0]   callback_id;
    } req_t;

    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   fired_id;
        logic              last;
    } result_t;

    // One timer slot as held in the slot memory.
    typedef struct packed {
        logic [TICK_W-1:0] start_tick;
        logic [TICK_W-1:0] delay_ticks;
        logic [ID_W-1:0]   action;
    } entry_t;

    typedef struct packed {
        logic tick;   // advance the tick counter
        logic arm0;   // arm slot 0 from the request ports
        logic load;   // capture the request and restart the slot walk
        logic find;   // look for the lowest free slot
        logic scan;   // service scan step
        logic flush;  // give the final scan result
    } ctl_t;

    typedef struct packed {
        logic free_at_idx;
        logic idx_last;
        logic scan_end;
    } stat_t;

endpackage
`default_nettype wire

@@ hdl/osdt_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// osdt_ctrl
// Controller state machine: decodes accepted requests and sequences the
// free-slot search and the service scan in the datapath.
// ----------------------------------------------------------------------------
module osdt_ctrl
    import osdt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire cmd_t  cmd,
    input  wire stat_t stat,
    output ctl_t       ctl,
    output logic       busy
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FIND  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        CMD_TICK: ctl.tick = 1'b1;
                        CMD_ADD0: ctl.arm0 = 1'b1;
                        CMD_ADD:
                        begin
                            ctl.load   = 1'b1;
                            state_next = ST_FIND;
                        end
                        CMD_SCAN:
                        begin
                            ctl.load   = 1'b1;
                            state_next = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_FIND:
            begin
                ctl.find = 1'b1;
                if (stat.free_at_idx || stat.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                ctl.scan = 1'b1;
                if (stat.scan_end)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                ctl.flush  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule
`default_nettype wire

@@ hdl/osdt_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// osdt_dpath
// Datapath: tick counter, slot active bits, slot memory, the one-slot-per-
// cycle walk with its registered read and expiry compare, and the result
// register.
// ----------------------------------------------------------------------------
module osdt_dpath
    import osdt_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire req_t request,
    input  wire ctl_t ctl,
    output stat_t     stat,
    output logic      strobe,
    output result_t   result
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);

    entry_t mem [NUM_SLOTS];

    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [NUM_SLOTS-1:0] active_reg, active_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 issue_done_reg, issue_done_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 strobe_reg, strobe_next;

    req_t                 req_reg, req_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]     pend_slot_reg, pend_slot_next;
    logic [ID_W-1:0]      pend_id_reg, pend_id_next;
    entry_t               rd_data_reg;
    result_t              result_reg, result_next;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    entry_t               mem_wdata;
    logic                 rd_en;
    logic [TICK_W-1:0]    elapsed;
    logic                 hit;

    // Modulo 2^32 elapsed time of the slot whose entry was read last cycle.
    assign elapsed = tick_reg - rd_data_reg.start_tick;
    assign hit     = chk_valid_reg && active_reg[chk_idx_reg]
                     && (elapsed >= rd_data_reg.delay_ticks)
                     && (cnt_reg < CNT_W'(MAX_RESULTS));

    assign stat.free_at_idx = !active_reg[idx_reg];
    assign stat.idx_last    = (idx_reg == IDX_LAST);
    assign stat.scan_end    = chk_valid_reg && (chk_idx_reg == IDX_LAST);

    always_comb
    begin
        tick_next       = tick_reg;
        active_next     = active_reg;
        idx_next        = idx_reg;
        issue_done_next = issue_done_reg;
        chk_valid_next  = 1'b0;
        pend_valid_next = pend_valid_reg;
        cnt_next        = cnt_reg;
        req_next        = req_reg;
        chk_idx_next    = chk_idx_reg;
        pend_slot_next  = pend_slot_reg;
        pend_id_next    = pend_id_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        rd_en           = 1'b0;
        strobe_next     = 1'b0;
        result_next     = '0;

        if (ctl.tick)
        begin
            tick_next = tick_reg + 1'b1;
        end

        if (ctl.arm0)
        begin
            mem_we               = 1'b1;
            mem_waddr            = '0;
            mem_wdata.start_tick = tick_reg;
            mem_wdata.delay_ticks = request.delay_ticks;
            mem_wdata.action     = request.callback_id;
            active_next[0]       = 1'b1;
            strobe_next          = 1'b1;
            result_next.kind     = KIND_ADDED;
            result_next.fired_id = request.callback_id;
            result_next.last     = 1'b1;
        end

        if (ctl.load)
        begin
            req_next        = request;
            idx_next        = '0;
            issue_done_next = 1'b0;
            pend_valid_next = 1'b0;
            cnt_next        = '0;
        end

        if (ctl.find)
        begin
            if (!active_reg[idx_reg])
            begin
                mem_we                = 1'b1;
                mem_waddr             = idx_reg;
                mem_wdata.start_tick  = tick_reg;
                mem_wdata.delay_ticks = req_reg.delay_ticks;
                mem_wdata.action      = req_reg.callback_id;
                active_next[idx_reg]  = 1'b1;
                strobe_next           = 1'b1;
                result_next.kind      = KIND_ADDED;
                result_next.slot      = SLOT_W'(idx_reg);
                result_next.fired_id  = req_reg.callback_id;
                result_next.last      = 1'b1;
            end
            else if (idx_reg == IDX_LAST)
            begin
                strobe_next      = 1'b1;
                result_next.kind = KIND_FULL;
                result_next.last = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end

        if (ctl.scan)
        begin
            if (!issue_done_reg)
            begin
                rd_en          = 1'b1;
                chk_valid_next = 1'b1;
                chk_idx_next   = idx_reg;
                if (idx_reg == IDX_LAST)
                begin
                    issue_done_next = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            // A fired slot is held back until the next one fires or the scan ends, so the final one can carry last.
            if (hit)
            begin
                active_next[chk_idx_reg] = 1'b0;
                cnt_next                 = cnt_reg + 1'b1;
                if (pend_valid_reg)
                begin
                    strobe_next          = 1'b1;
                    result_next.kind     = KIND_FIRED;
                    result_next.slot     = SLOT_W'(pend_slot_reg);
                    result_next.fired_id = pend_id_reg;
                end
                pend_valid_next = 1'b1;
                pend_slot_next  = chk_idx_reg;
                pend_id_next    = rd_data_reg.action;
            end
        end

        if (ctl.flush)
        begin
            strobe_next      = 1'b1;
            result_next.last = 1'b1;
            if (pend_valid_reg)
            begin
                result_next.kind     = KIND_FIRED;
                result_next.slot     = SLOT_W'(pend_slot_reg);
                result_next.fired_id = pend_id_reg;
            end
            else
            begin
                result_next.kind = KIND_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= '0;
            active_reg     <= '0;
            idx_reg        <= '0;
            issue_done_reg <= 1'b0;
            chk_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            tick_reg       <= tick_next;
            active_reg     <= active_next;
            idx_reg        <= idx_next;
            issue_done_reg <= issue_done_next;
            chk_valid_reg  <= chk_valid_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        chk_idx_reg   <= chk_idx_next;
        pend_slot_reg <= pend_slot_next;
        pend_id_reg   <= pend_id_next;
        result_reg    <= result_next;
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

@@ hdl/one_shot_delay_timer_table_core.sv @@
// A tick or an add at slot 0 is taken with busy staying low, and the add gives its
// result in the next cycle. An add to the first free slot checks one slot per cycle
// and registers its result once it finds a free slot or reaches the last slot.
// A service scan keeps busy high through the slot walk and a final flush; a fired
// result is held back until the next one fires, and the final one comes from the flush.
// A new request is taken as soon as busy falls. Reset clears the tick counter and all active bits.
`default_nettype none
// ----------------------------------------------------------------------------
// one_shot_delay_timer_table_core
// Bank of one-shot delay timers on a 32-bit tick counter advanced by tick
// requests, with add, overwrite and service scan requests.
// ----------------------------------------------------------------------------
module one_shot_delay_timer_table_core
    import osdt_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire req_t request,
    output logic      busy,
    output logic      strobe,
    output result_t   result
);

    ctl_t  ctl;
    stat_t stat;

    osdt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (request.cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    osdt_dpath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .ctl     (ctl),
        .stat    (stat),
        .strobe  (strobe),
        .result  (result)
    );

endmodule
`default_nettype wire

@@ hdl/osdt_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// osdt_checker
// Port-level checks of the timer table, attached to the top level by bind.
// ----------------------------------------------------------------------------
module osdt_checker
    import osdt_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire req_t    request,
    input wire logic    busy,
    input wire logic    strobe,
    input wire result_t result
);

    // Every result other than a fired timer ends its request; a fired one ends it only when final.
    a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.kind != KIND_FIRED) |-> result.last)
        else $error("non-fired result without last");

    a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (request.cmd == CMD_TICK) |=> !strobe)
        else $error("tick request produced a result");

    a_add0_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (request.cmd == CMD_ADD0) |=>
            strobe && (result.kind == KIND_ADDED) && (result.slot == '0)
            && (result.fired_id == $past(request.callback_id)) && result.last)
        else $error("overwrite of slot 0 gave a wrong result");

    a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.kind == KIND_FULL) |->
            (result.slot == '0) && (result.fired_id == '0))
        else $error("table full result with nonzero fields");

    a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && ((request.cmd == CMD_ADD) || (request.cmd == CMD_SCAN))
            |=> busy)
        else $error("slot walk did not raise busy");

endmodule

bind one_shot_delay_timer_table_core osdt_checker u_osdt_checker (.*);
`default_nettype wire

@@ bench/one_shot_delay_timer_table_core_test.sv @@
// ----------------------------------------------------------------------------
// one_shot_delay_timer_table_core_test
// Self-checking bench for the one-shot delay timer table. A directed table
// covers reset, the field extremes, table full, slot 0 overwrite, zero delay
// and zero callback id. Random ticks, adds and scans follow, including
// bursts that fill the table and expire many slots in one scan. Every result
// is checked against its directed row or an in-bench model of the slot table.
// ----------------------------------------------------------------------------
module one_shot_delay_timer_table_core_test;
    import osdt_pkg::*;

    localparam int NUM_SLOTS    = 8;
    localparam int RANDOM_ITEMS = 88;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        req_t    req;
        bit      typed;
        result_t want;
    } plan_row_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    req_t    request;
    logic    busy;
    logic    strobe;
    result_t result;

    // Model of the slot table.
    logic [TICK_W-1:0] tick_now;
    logic              slot_armed [NUM_SLOTS];
    logic [TICK_W-1:0] slot_from  [NUM_SLOTS];
    logic [TICK_W-1:0] slot_span  [NUM_SLOTS];
    logic [ID_W-1:0]   slot_tag   [NUM_SLOTS];

    result_t   fresh[$];
    result_t   awaited[$];
    plan_row_t plan[$];

    int  mismatches = 0;
    int  cycles = 0;
    int  results_seen = 0;
    int  fired_count = 0;
    int  full_count = 0;
    int  cmd_count [4];
    bit  no_idle = 1'b0;

    one_shot_delay_timer_table_core #(
        .NUM_SLOTS (NUM_SLOTS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .strobe  (strobe),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("one_shot_delay_timer_table_core: mismatch");
            $finish;
        end
    end

    function automatic result_t make_result(kind_t kind, int slot, int id, bit last);
        result_t r;
        r.kind     = kind;
        r.slot     = slot[SLOT_W-1:0];
        r.fired_id = id[ID_W-1:0];
        r.last     = last;
        return r;
    endfunction

    function automatic void load_slot(int s, req_t r);
        slot_armed[s] = 1'b1;
        slot_from[s]  = tick_now;
        slot_span[s]  = r.delay_ticks;
        slot_tag[s]   = r.callback_id;
    endfunction

    // Applies one request to the table model and leaves its results in fresh.
    function automatic void predict_timers(req_t r);
        logic [TICK_W-1:0] elapsed;
        bit placed;
        fresh.delete();
        placed = 1'b0;
        case (r.cmd)
            CMD_TICK:
                tick_now = tick_now + 1'b1;
            CMD_ADD:
            begin
                for (int s = 0; s < NUM_SLOTS; s++)
                begin
                    if (!placed && !slot_armed[s])
                    begin
                        load_slot(s, r);
                        fresh.push_back(make_result(KIND_ADDED, s, r.callback_id, 1'b1));
                        placed = 1'b1;
                    end
                end
                if (!placed)
                begin
                    fresh.push_back(make_result(KIND_FULL, 0, 0, 1'b1));
                    full_count++;
                end
            end
            CMD_ADD0:
            begin
                load_slot(0, r);
                fresh.push_back(make_result(KIND_ADDED, 0, r.callback_id, 1'b1));
            end
            default:
            begin
                for (int s = 0; s < NUM_SLOTS && fresh.size() < MAX_RESULTS; s++)
                begin
                    elapsed = tick_now - slot_from[s];
                    if (slot_armed[s] && elapsed >= slot_span[s])
                    begin
                        fresh.push_back(make_result(KIND_FIRED, s, slot_tag[s], 1'b0));
                        slot_armed[s] = 1'b0;
                        slot_span[s]  = '0;
                        slot_tag[s]   = '0;
                        fired_count++;
                    end
                end
                if (fresh.size() == 0)
                    fresh.push_back(make_result(KIND_NONE, 0, 0, 1'b1));
                else
                    fresh[fresh.size()-1].last = 1'b1;
            end
        endcase
    endfunction

    function automatic req_t make_req(cmd_t cmd, logic [TICK_W-1:0] delay, int id);
        req_t r;
        r.cmd         = cmd;
        r.delay_ticks = delay;
        r.callback_id = id[ID_W-1:0];
        return r;
    endfunction

    // Mostly short delays so that timers actually expire during the run.
    function automatic req_t random_request();
        req_t r;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            r.cmd = CMD_TICK;
        else if (roll < 58)
            r.cmd = CMD_ADD;
        else if (roll < 68)
            r.cmd = CMD_ADD0;
        else
            r.cmd = CMD_SCAN;
        case ($urandom_range(0, 9))
            0: r.delay_ticks = $urandom;
            1: r.delay_ticks = '1;
            default: r.delay_ticks = $urandom_range(0, 12);
        endcase
        r.callback_id = ID_W'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic plan_row_t row(cmd_t cmd, logic [TICK_W-1:0] delay, int id,
                                      bit typed, kind_t kind, int slot, int fid);
        plan_row_t p;
        p.req   = make_req(cmd, delay, id);
        p.typed = typed;
        p.want  = make_result(kind, slot, fid, 1'b1);
        return p;
    endfunction

    task automatic issue_request(req_t r, bit typed, result_t want);
        int gap;
        if (!no_idle && $urandom_range(0, 99) < 27)
        begin
            gap = $urandom_range(1, 4);
            repeat (gap)
            begin
                @(negedge clk);
                start   <= 1'b0;
                request <= random_request();
            end
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        predict_timers(r);
        cmd_count[r.cmd]++;
        if (typed)
            awaited.push_back(want);
        else
            foreach (fresh[i])
                awaited.push_back(fresh[i]);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && strobe !== 1'b0)
        begin
            results_seen++;
            if (awaited.size() == 0)
            begin
                $error("result with no request outstanding: kind %0d slot %0d id %0d",
                       result.kind, result.slot, result.fired_id);
                mismatches++;
            end
            else
            begin
                want = awaited.pop_front();
                if (result.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, result.kind);
                    mismatches++;
                end
                if (result.slot !== want.slot)
                begin
                    $error("slot: expected %0d, got %0d", want.slot, result.slot);
                    mismatches++;
                end
                if (result.fired_id !== want.fired_id)
                begin
                    $error("fired_id: expected %0d, got %0d", want.fired_id, result.fired_id);
                    mismatches++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, result.last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int sent;
        bit paused;
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        tick_now = '0;
        paused  = 1'b0;
        foreach (cmd_count[i])
            cmd_count[i] = 0;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            slot_armed[s] = 1'b0;
            slot_from[s]  = '0;
            slot_span[s]  = '0;
            slot_tag[s]   = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        plan.push_back(row(CMD_SCAN, 0, 0, 1'b1, KIND_NONE, 0, 0));
        plan.push_back(row(CMD_ADD, 0, 8'hFF, 1'b1, KIND_ADDED, 0, 8'hFF));
        plan.push_back(row(CMD_ADD, 32'hFFFF_FFFF, 8'h00, 1'b1, KIND_ADDED, 1, 8'h00));
        plan.push_back(row(CMD_ADD, 1, 8'h55, 1'b1, KIND_ADDED, 2, 8'h55));
        plan.push_back(row(CMD_ADD, 2, 8'hAA, 1'b1, KIND_ADDED, 3, 8'hAA));
        plan.push_back(row(CMD_SCAN, 0, 0, 1'b0, KIND_NONE, 0, 0));
        plan.push_back(row(CMD_TICK, 0, 0, 1'b0, KIND_NONE, 0, 0));
        plan.push_back(row(CMD_SCAN, 0, 0, 1'b0, KIND_NONE, 0, 0));
        plan.push_back(row(CMD_ADD0, 32'h8000_0000, 8'h81, 1'b1, KIND_ADDED, 0, 8'h81));
        plan.push_back(row(CMD_ADD, 3, 8'h01, 1'b0, KIND_NONE, 0, 0));
        plan.push_back(row(CMD_ADD, 0, 8'h80, 1'b0, KIND_NONE, 0, 0));
        plan.push_back(row(CMD_ADD, 7, 8'h7F, 1'b0, KIND_NONE, 0, 0));
        plan.push_back(row(CMD_ADD, 32'h7FFF_FFFF, 8'hFE, 1'b0, KIND_NONE, 0, 0));
        plan.push_back(row(CMD_ADD, 0, 8'h00, 1'b0, KIND_NONE, 0, 0));
        plan.push_back(row(CMD_ADD, 5, 8'h33, 1'b1, KIND_FULL, 0, 0));
        // Overwriting slot 0 drops its pending timer without a report.
        plan.push_back(row(CMD_ADD0, 0, 8'h7E, 1'b1, KIND_ADDED, 0, 8'h7E));
        plan.push_back(row(CMD_TICK, 0, 0, 1'b0, KIND_NONE, 0, 0));
        plan.push_back(row(CMD_TICK, 0, 0, 1'b0, KIND_NONE, 0, 0));
        plan.push_back(row(CMD_TICK, 0, 0, 1'b0, KIND_NONE, 0, 0));
        plan.push_back(row(CMD_SCAN, 0, 0, 1'b0, KIND_NONE, 0, 0));
        plan.push_back(row(CMD_SCAN, 0, 0, 1'b0, KIND_NONE, 0, 0));
        plan.push_back(row(CMD_TICK, 32'hFFFF_FFFF, 8'hFF, 1'b0, KIND_NONE, 0, 0));

        foreach (plan[i])
            issue_request(plan[i].req, plan[i].typed, plan[i].want);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            no_idle = (sent >= 20 && sent < 50);
            if (!paused && sent >= 70)
            begin
                // Hold off once until every outstanding result is back.
                paused = 1'b1;
                @(negedge clk);
                start <= 1'b0;
                while (awaited.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 99) < 8)
            begin
                // Fill the table with short timers, then expire them together.
                repeat (NUM_SLOTS)
                    issue_request(make_req(CMD_ADD, $urandom_range(0, 1),
                                           $urandom_range(0, 255)), 1'b0, '0);
                issue_request(make_req(CMD_TICK, $urandom, $urandom_range(0, 255)), 1'b0, '0);
                issue_request(make_req(CMD_SCAN, $urandom, $urandom_range(0, 255)), 1'b0, '0);
                sent += NUM_SLOTS + 2;
            end
            else
            begin
                issue_request(random_request(), 1'b0, '0);
                sent++;
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (NUM_SLOTS + 4) @(posedge clk);

        $display("Requests: %0d ticks, %0d adds, %0d slot 0 overwrites, %0d scans.",
                 cmd_count[CMD_TICK], cmd_count[CMD_ADD], cmd_count[CMD_ADD0],
                 cmd_count[CMD_SCAN]);
        $display("Results checked: %0d, with %0d timers fired and %0d full tables.",
                 results_seen, fired_count, full_count);
        if (mismatches == 0)
            $display("one_shot_delay_timer_table_core: match");
        else
            $display("one_shot_delay_timer_table_core: mismatch");
        $finish;
    end

endmodule
